// ===== src/qrst_pkg.sv =====
package qrst_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_W    = 3;

  typedef logic signed [15:0] q412_t;   // Q4.12 coordinate or scale
  typedef logic signed [17:0] cval_t;   // CORDIC x, y in Q1.14 with growth margin
  typedef logic signed [16:0] zval_t;   // residual angle
  typedef logic signed [33:0] prod_t;   // 16 x 18 product
  typedef logic signed [17:0] rot_t;    // rotated coordinate, unsaturated
  typedef logic signed [33:0] sprod_t;  // rotated coordinate times scale

  localparam cval_t CORDIC_GAIN = 18'sd9949;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Fields that ride along with an angle through the CORDIC stages.
  typedef struct packed {
    q412_t      pos_x;
    q412_t      pos_y;
    q412_t      scale_x;
    q412_t      scale_y;
    logic [1:0] quad;
  } item_t;

  // atan(2^-i) in units of a full turn / 65536.
  function automatic zval_t atan_turn(input int i);
    zval_t r;
    case (i)
      0:       r = 17'sd8192;
      1:       r = 17'sd4836;
      2:       r = 17'sd2555;
      3:       r = 17'sd1297;
      4:       r = 17'sd651;
      5:       r = 17'sd326;
      6:       r = 17'sd163;
      7:       r = 17'sd81;
      8:       r = 17'sd41;
      9:       r = 17'sd20;
      10:      r = 17'sd10;
      11:      r = 17'sd5;
      12:      r = 17'sd3;
      13:      r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

  function automatic q412_t corner_reset(input int i);
    q412_t r;
    case (i)
      0, 1, 2, 7: r = 16'sd2048;
      default:    r = -16'sd2048;
    endcase
    return r;
  endfunction

endpackage

// ===== src/quad_rotate_scale_translate.sv =====
// Rotates the four configured quad corners by angle, scales x and y per axis and
// adds the position, giving all eight saturated Q4.12 coordinates in one word.
// The block is a fixed pipeline of 20 register stages (the input register, one per
// CORDIC iteration, then quadrant fold, products, rotation sum, scale product,
// round/add/saturate): a word accepted at a clock edge passes through these stages
// in order and shows on the outputs together with done high. A new word can start
// every cycle; busy stays low and results cannot be held off, so done must be taken
// when it is high.
// Corner registers may be written only while no word is in flight.
module quad_rotate_scale_translate (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  qrst_pkg::q412_t                pos_x,
  input  qrst_pkg::q412_t                pos_y,
  input  qrst_pkg::q412_t                scale_x,
  input  qrst_pkg::q412_t                scale_y,
  input  logic [15:0]                    angle,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrst_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           done,
  output qrst_pkg::q412_t                out0_x,
  output qrst_pkg::q412_t                out0_y,
  output qrst_pkg::q412_t                out1_x,
  output qrst_pkg::q412_t                out1_y,
  output qrst_pkg::q412_t                out2_x,
  output qrst_pkg::q412_t                out2_y,
  output qrst_pkg::q412_t                out3_x,
  output qrst_pkg::q412_t                out3_y
);
  import qrst_pkg::*;

  q412_t corner_reg [0:NUM_REGS-1];

  // CORDIC stages
  logic  cv   [0:CORDIC_STEPS];
  cval_t cx   [0:CORDIC_STEPS];
  cval_t cy   [0:CORDIC_STEPS];
  zval_t cz   [0:CORDIC_STEPS];
  item_t citm [0:CORDIC_STEPS];

  // Quadrant fold stage
  logic  qv;
  cval_t cos_r;
  cval_t sin_r;
  q412_t qpos  [0:1];
  q412_t qscl  [0:1];

  // Product stage
  logic  pv;
  prod_t pa   [0:NUM_REGS-1];
  prod_t pb   [0:NUM_REGS-1];
  q412_t ppos [0:1];
  q412_t pscl [0:1];

  // Rotation sum stage
  logic  rv;
  rot_t  rot  [0:NUM_REGS-1];
  q412_t rpos [0:1];
  q412_t rscl [0:1];

  // Scale product stage
  logic   sv;
  sprod_t sp   [0:NUM_REGS-1];
  q412_t  spos [0:1];

  // Output stage
  q412_t res [0:NUM_REGS-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        corner_reg[i] <= corner_reset(i);
      end
    end else if (cfg_valid) begin
      corner_reg[cfg_index] <= cfg_data;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cv[i] <= 1'b0;
      end
      qv   <= 1'b0;
      pv   <= 1'b0;
      rv   <= 1'b0;
      sv   <= 1'b0;
      done <= 1'b0;
    end else begin
      cv[0] <= start;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        cv[i] <= cv[i-1];
      end
      qv   <= cv[CORDIC_STEPS];
      pv   <= qv;
      rv   <= pv;
      sv   <= rv;
      done <= sv;
    end
  end

  always_ff @(posedge clk) begin
    cx[0]           <= CORDIC_GAIN;
    cy[0]           <= '0;
    cz[0]           <= zval_t'({3'b000, angle[13:0]});
    citm[0].pos_x   <= pos_x;
    citm[0].pos_y   <= pos_y;
    citm[0].scale_x <= scale_x;
    citm[0].scale_y <= scale_y;
    citm[0].quad    <= angle[15:14];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cval_t dx;
    cval_t dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (!cz[i][16]) begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - atan_turn(i);
      end else begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + atan_turn(i);
      end
      citm[i+1] <= citm[i];
    end
  end

  // The CORDIC covers one quarter turn; the top angle bits swap and negate.
  always_ff @(posedge clk) begin
    case (citm[CORDIC_STEPS].quad)
      QUAD_0: begin
        cos_r <= cx[CORDIC_STEPS];
        sin_r <= cy[CORDIC_STEPS];
      end
      QUAD_1: begin
        cos_r <= -cy[CORDIC_STEPS];
        sin_r <= cx[CORDIC_STEPS];
      end
      QUAD_2: begin
        cos_r <= -cx[CORDIC_STEPS];
        sin_r <= -cy[CORDIC_STEPS];
      end
      default: begin
        cos_r <= cy[CORDIC_STEPS];
        sin_r <= -cx[CORDIC_STEPS];
      end
    endcase
    qpos[0] <= citm[CORDIC_STEPS].pos_x;
    qpos[1] <= citm[CORDIC_STEPS].pos_y;
    qscl[0] <= citm[CORDIC_STEPS].scale_x;
    qscl[1] <= citm[CORDIC_STEPS].scale_y;
  end

  always_ff @(posedge clk) begin
    ppos <= qpos;
    pscl <= qscl;
    rpos <= ppos;
    rscl <= pscl;
    spos <= rpos;
  end

  // Lane 2k is corner k's x, lane 2k+1 its y.
  for (genvar k = 0; k < NUM_REGS / 2; k++) begin : g_corner
    logic signed [34:0] sum_x;
    logic signed [34:0] sum_y;

    assign sum_x = 35'(pa[2*k]) - 35'(pb[2*k]) + 35'sd8192;
    assign sum_y = 35'(pa[2*k+1]) + 35'(pb[2*k+1]) + 35'sd8192;

    always_ff @(posedge clk) begin
      pa[2*k]     <= corner_reg[2*k] * cos_r;
      pb[2*k]     <= corner_reg[2*k+1] * sin_r;
      pa[2*k+1]   <= corner_reg[2*k+1] * cos_r;
      pb[2*k+1]   <= corner_reg[2*k] * sin_r;
      rot[2*k]    <= rot_t'(sum_x >>> 14);
      rot[2*k+1]  <= rot_t'(sum_y >>> 14);
    end
  end

  for (genvar j = 0; j < NUM_REGS; j++) begin : g_lane
    logic signed [34:0] rnd;
    logic signed [22:0] moved;

    assign rnd   = 35'(sp[j]) + 35'sd2048;
    assign moved = 23'(rnd >>> 12) + 23'(spos[j % 2]);

    always_ff @(posedge clk) begin
      sp[j] <= rot[j] * rscl[j % 2];
      if (moved > 23'sd32767) begin
        res[j] <= 16'sh7fff;
      end else if (moved < -23'sd32768) begin
        res[j] <= 16'sh8000;
      end else begin
        res[j] <= moved[15:0];
      end
    end
  end

  assign out0_x = res[0];
  assign out0_y = res[1];
  assign out1_x = res[2];
  assign out1_y = res[3];
  assign out2_x = res[4];
  assign out2_y = res[5];
  assign out3_x = res[6];
  assign out3_y = res[7];

endmodule
